[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the prelu rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define QP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge outside reset
`define QP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/qprelu_pkg.sv]
// ---------------------------------------------------------------------------
// qprelu_pkg
// types and constants of the quantized prelu block
// ---------------------------------------------------------------------------
package qprelu_pkg;

    localparam int VALUE_W       = 8;
    localparam int INDEX_W       = 8;
    localparam int CHAN_OUT_W    = 8;
    localparam int SLOPE_DEPTH   = 256;
    localparam int CHAN_FIELD_W  = 9;
    localparam int PLANE_FIELD_W = 21;
    localparam int GAIN_W        = 32;

    localparam int X_W    = 9;
    localparam int XS_W   = 2 * X_W;
    localparam int PROD_W = XS_W + GAIN_W + 1;
    localparam int FRAC_W = 24;
    localparam int R_W    = PROD_W - FRAC_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_DATA_KIND      = 3'd0;
    localparam logic [2:0] REG_INPUT_OFFSET   = 3'd1;
    localparam logic [2:0] REG_SLOPE_OFFSET   = 3'd2;
    localparam logic [2:0] REG_OUTPUT_OFFSET  = 3'd3;
    localparam logic [2:0] REG_CHANNEL_TOTAL  = 3'd4;
    localparam logic [2:0] REG_PLANE_ELEMENTS = 3'd5;
    localparam logic [2:0] REG_POS_GAIN       = 3'd6;
    localparam logic [2:0] REG_NEG_GAIN       = 3'd7;

    localparam logic KIND_UINT8 = 1'b0;
    localparam logic KIND_INT8  = 1'b1;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 32'd16777216;
    localparam logic [PROD_W-1:0] Q_HALF  = PROD_W'(64'd8388608);

    localparam int OUT_HI_U8 = 255;
    localparam int OUT_HI_I8 = 127;
    localparam int OUT_LO_I8 = -127;

    typedef struct packed {
        logic               load;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } entry_t;

    typedef struct packed {
        logic [CHAN_FIELD_W-1:0]  channel_total;
        logic [PLANE_FIELD_W-1:0] plane_elements;
    } size_t;

    typedef struct packed {
        logic               data_kind;
        logic [VALUE_W-1:0] input_offset;
        logic [VALUE_W-1:0] slope_offset;
        logic [VALUE_W-1:0] output_offset;
        logic [GAIN_W-1:0]  pos_gain;
        logic [GAIN_W-1:0]  neg_gain;
    } arith_cfg_t;

endpackage

[rtl/qprelu_front.sv]
// ---------------------------------------------------------------------------
// qprelu_front
// accepts input transfers, tags data elements with their channel and
// advances the plane and channel counters
// ---------------------------------------------------------------------------
module qprelu_front #(
    parameter int CHANNEL_MAX = 256,
    parameter int PLANE_MAX   = 1048576
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_mode,
    input  logic [7:0]          in_value,
    input  logic [7:0]          in_index,
    input  qprelu_pkg::size_t   size,
    input  logic                q_full,
    output logic                q_push,
    output qprelu_pkg::entry_t  q_entry
);

    localparam int PW  = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1;
    localparam int PLW = (PW + 1 > qprelu_pkg::PLANE_FIELD_W) ? PW + 1
                                                              : qprelu_pkg::PLANE_FIELD_W;
    localparam int CW  = (CHANNEL_MAX > 1) ? $clog2(CHANNEL_MAX) : 1;
    localparam int CLW = (CW + 1 > qprelu_pkg::CHAN_FIELD_W) ? CW + 1
                                                             : qprelu_pkg::CHAN_FIELD_W;

    logic [PW-1:0]  plane_pos_reg;
    logic [PW-1:0]  plane_pos_next;
    logic [CW-1:0]  chan_pos_reg;
    logic [CW-1:0]  chan_pos_next;
    logic [PLW-1:0] plane_set;
    logic [PLW-1:0] plane_lim;
    logic [PLW-1:0] plane_inc;
    logic [CLW-1:0] chan_set;
    logic [CLW-1:0] chan_lim;
    logic [CLW-1:0] chan_inc;
    logic           advance;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign advance  = q_push && (in_mode == qprelu_pkg::MODE_DATA);

    assign q_entry.load  = in_mode;
    assign q_entry.value = in_value;
    assign q_entry.index = (in_mode == qprelu_pkg::MODE_LOAD) ? in_index
                                                              : qprelu_pkg::INDEX_W'(chan_pos_reg);

    // clamp the plane and channel sizes into 1..max
    always_comb
    begin
        plane_set = PLW'(size.plane_elements);
        if (plane_set == '0)
        begin
            plane_lim = PLW'(1);
        end
        else if (plane_set > PLW'(PLANE_MAX))
        begin
            plane_lim = PLW'(PLANE_MAX);
        end
        else
        begin
            plane_lim = plane_set;
        end

        chan_set = CLW'(size.channel_total);
        if (chan_set == '0)
        begin
            chan_lim = CLW'(1);
        end
        else if (chan_set > CLW'(CHANNEL_MAX))
        begin
            chan_lim = CLW'(CHANNEL_MAX);
        end
        else
        begin
            chan_lim = chan_set;
        end
    end

    always_comb
    begin
        plane_inc      = PLW'(plane_pos_reg) + PLW'(1);
        chan_inc       = CLW'(chan_pos_reg) + CLW'(1);
        plane_pos_next = plane_pos_reg;
        chan_pos_next  = chan_pos_reg;
        if (advance)
        begin
            if (plane_inc >= plane_lim)
            begin
                plane_pos_next = '0;
                if (chan_inc >= chan_lim)
                begin
                    chan_pos_next = '0;
                end
                else
                begin
                    chan_pos_next = CW'(chan_inc);
                end
            end
            else
            begin
                plane_pos_next = PW'(plane_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_pos_reg <= '0;
            chan_pos_reg  <= '0;
        end
        else
        begin
            plane_pos_reg <= plane_pos_next;
            chan_pos_reg  <= chan_pos_next;
        end
    end

endmodule

[rtl/qprelu_queue.sv]
// ---------------------------------------------------------------------------
// qprelu_queue
// short fifo between the front and the back part
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qprelu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  qprelu_pkg::entry_t  push_entry,
    output logic                full,
    input  logic                pop,
    output qprelu_pkg::entry_t  pop_entry,
    output logic                empty
);

    qprelu_pkg::entry_t                 slot_reg [qprelu_pkg::QUEUE_DEPTH];
    logic [qprelu_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [qprelu_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [qprelu_pkg::QCNT_W-1:0]      count_reg;
    logic [qprelu_pkg::QCNT_W-1:0]      count_next;

    assign full      = (count_reg == qprelu_pkg::QCNT_W'(qprelu_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + qprelu_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - qprelu_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + qprelu_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + qprelu_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `QP_ASSERT_NEVER(a_count_bound, count_reg > qprelu_pkg::QCNT_W'(qprelu_pkg::QUEUE_DEPTH), "queue count past depth")
    `QP_ASSERT(a_count_grow, (push && !pop) |=> count_reg == $past(count_reg) + qprelu_pkg::QCNT_W'(1), "queue count did not follow a lone push")

endmodule

[rtl/qprelu_back.sv]
// ---------------------------------------------------------------------------
// qprelu_back
// slope table, pipelined prelu arithmetic with rounding and clamping,
// and the output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qprelu_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qprelu_pkg::arith_cfg_t  cfg,
    input  logic                    q_empty,
    input  qprelu_pkg::entry_t      q_entry,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_result,
    output logic                    out_clipped,
    output logic [7:0]              out_channel
);

    localparam int XW = qprelu_pkg::X_W;
    localparam int SW = qprelu_pkg::XS_W;
    localparam int PW = qprelu_pkg::PROD_W;
    localparam int RW = qprelu_pkg::R_W;
    localparam int FW = qprelu_pkg::FRAC_W;

    logic [7:0] slope_table [qprelu_pkg::SLOPE_DEPTH];

    logic adv;

    // stage 1: table read
    logic        s1_valid_reg;
    logic [7:0]  s1_value_reg;
    logic [7:0]  s1_chan_reg;
    logic [7:0]  tab_rd_reg;

    // stage 2: offsets and slope product
    logic                 s2_valid_reg;
    logic [7:0]           s2_chan_reg;
    logic                 s2_pos_reg;
    logic signed [XW-1:0] s2_x_reg;
    logic signed [SW-1:0] s2_xs_reg;
    logic signed [XW-1:0] x_val;
    logic signed [XW-1:0] s_val;
    logic signed [SW-1:0] xs_val;

    // stage 3: gain product
    logic                 s3_valid_reg;
    logic [7:0]           s3_chan_reg;
    logic signed [PW-1:0] s3_prod_reg;
    logic signed [SW-1:0] mul_a;
    logic signed [qprelu_pkg::GAIN_W:0] mul_b;
    logic signed [PW-1:0] prod_val;

    // stage 4: output zero point
    logic                 s4_valid_reg;
    logic [7:0]           s4_chan_reg;
    logic signed [PW-1:0] s4_t_reg;
    logic signed [PW-1:0] t_val;

    // output register
    logic                 out_valid_reg;
    logic [7:0]           out_result_reg;
    logic                 out_clipped_reg;
    logic [7:0]           out_chan_reg;
    logic [PW-1:0]        rnd_val;
    logic signed [RW-1:0] r_val;
    logic signed [RW-1:0] r_hi;
    logic signed [RW-1:0] r_lo;
    logic [7:0]           res_val;
    logic                 clip_val;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    assign out_valid   = out_valid_reg;
    assign out_result  = out_result_reg;
    assign out_clipped = out_clipped_reg;
    assign out_channel = out_chan_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_entry.load)
        begin
            slope_table[q_entry.index] <= q_entry.value;
        end
        if (adv)
        begin
            tab_rd_reg <= slope_table[q_entry.index];
        end
    end

    always_comb
    begin
        if (cfg.data_kind == qprelu_pkg::KIND_UINT8)
        begin
            x_val = $signed({1'b0, s1_value_reg}) - $signed({1'b0, cfg.input_offset});
            s_val = $signed({1'b0, tab_rd_reg}) - $signed({1'b0, cfg.slope_offset});
        end
        else
        begin
            x_val = $signed({s1_value_reg[7], s1_value_reg});
            s_val = $signed({tab_rd_reg[7], tab_rd_reg});
        end
        xs_val = x_val * s_val;
    end

    always_comb
    begin
        if (s2_pos_reg)
        begin
            mul_a = SW'(s2_x_reg);
            mul_b = $signed({1'b0, cfg.pos_gain});
        end
        else
        begin
            mul_a = s2_xs_reg;
            mul_b = $signed({1'b0, cfg.neg_gain});
        end
        prod_val = mul_a * mul_b;
    end

    always_comb
    begin
        if (cfg.data_kind == qprelu_pkg::KIND_UINT8)
        begin
            t_val = s3_prod_reg + $signed({{(PW - 8 - FW){1'b0}}, cfg.output_offset,
                                          {FW{1'b0}}});
        end
        else
        begin
            t_val = s3_prod_reg;
        end
    end

    // half away from zero: add one half, less one when negative, then floor
    always_comb
    begin
        rnd_val = s4_t_reg + qprelu_pkg::Q_HALF - {{(PW - 1){1'b0}}, s4_t_reg[PW-1]};
        r_val   = $signed(rnd_val[PW-1:FW]);
        if (cfg.data_kind == qprelu_pkg::KIND_UINT8)
        begin
            r_hi = RW'(qprelu_pkg::OUT_HI_U8);
            r_lo = '0;
        end
        else
        begin
            r_hi = RW'(qprelu_pkg::OUT_HI_I8);
            r_lo = RW'(qprelu_pkg::OUT_LO_I8);
        end
        if (r_val > r_hi)
        begin
            res_val  = r_hi[7:0];
            clip_val = 1'b1;
        end
        else if (r_val < r_lo)
        begin
            res_val  = r_lo[7:0];
            clip_val = 1'b1;
        end
        else
        begin
            res_val  = r_val[7:0];
            clip_val = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_value_reg    <= q_entry.value;
            s1_chan_reg     <= q_entry.index;
            s2_chan_reg     <= s1_chan_reg;
            s2_pos_reg      <= (x_val > 0);
            s2_x_reg        <= x_val;
            s2_xs_reg       <= xs_val;
            s3_chan_reg     <= s2_chan_reg;
            s3_prod_reg     <= prod_val;
            s4_chan_reg     <= s3_chan_reg;
            s4_t_reg        <= t_val;
            out_chan_reg    <= s4_chan_reg;
            out_result_reg  <= res_val;
            out_clipped_reg <= clip_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_pop && !q_entry.load;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    `QP_ASSERT(a_stall_hold, !adv |=> $stable(s4_valid_reg) && $stable(s1_valid_reg), "pipeline moved during stall")

endmodule

[rtl/quantized_prelu_activation_top.sv]
// ---------------------------------------------------------------------------
// quantized_prelu_activation_top
// per-channel prelu on quantized nchw elements, apb register port
// ---------------------------------------------------------------------------
// Takes one transfer per cycle while the queue is not full and, once the
// pipeline has filled, returns one result per cycle while the master side
// is ready; a data element waits in the queue until the back pipeline
// advances and then passes the table read, three arithmetic stages and the
// output register before it is offered on the master side.
// The back pipeline advances as a whole whenever its output register is
// free, so a stalled master side holds it while the four-entry queue keeps
// taking transfers. Load transfers write the slope table and give no
// result. The slope table has no clearing pass; entries read before they
// are loaded are undefined. Registers sit at byte address 4*i.
module quantized_prelu_activation_top #(
    parameter int CHANNEL_MAX = 256,
    parameter int PLANE_MAX   = 1048576
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // value, slope_index
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // result, channel
    output logic                              m_tuser,   // clipped
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qprelu_pkg::PADDR_W-1:0]    paddr,
    input  logic [qprelu_pkg::PDATA_W-1:0]    pwdata,
    output logic [qprelu_pkg::PDATA_W-1:0]    prdata,
    output logic                              pready
);

    logic                                       data_kind_reg;
    logic [7:0]                                 input_offset_reg;
    logic [7:0]                                 slope_offset_reg;
    logic [7:0]                                 output_offset_reg;
    logic [qprelu_pkg::CHAN_FIELD_W-1:0]        channel_total_reg;
    logic [qprelu_pkg::PLANE_FIELD_W-1:0]       plane_elements_reg;
    logic [qprelu_pkg::GAIN_W-1:0]              pos_gain_reg;
    logic [qprelu_pkg::GAIN_W-1:0]              neg_gain_reg;

    logic                    cfg_wr;
    logic [2:0]              reg_sel;
    qprelu_pkg::size_t       size;
    qprelu_pkg::arith_cfg_t  arith_cfg;
    qprelu_pkg::entry_t      push_entry;
    qprelu_pkg::entry_t      pop_entry;
    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    logic [7:0]              res_result;
    logic [7:0]              res_channel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_kind_reg      <= qprelu_pkg::KIND_UINT8;
            input_offset_reg   <= '0;
            slope_offset_reg   <= '0;
            output_offset_reg  <= '0;
            channel_total_reg  <= qprelu_pkg::CHAN_FIELD_W'(1);
            plane_elements_reg <= qprelu_pkg::PLANE_FIELD_W'(1);
            pos_gain_reg       <= qprelu_pkg::GAIN_ONE;
            neg_gain_reg       <= qprelu_pkg::GAIN_ONE;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                qprelu_pkg::REG_DATA_KIND:      data_kind_reg      <= pwdata[0];
                qprelu_pkg::REG_INPUT_OFFSET:   input_offset_reg   <= pwdata[7:0];
                qprelu_pkg::REG_SLOPE_OFFSET:   slope_offset_reg   <= pwdata[7:0];
                qprelu_pkg::REG_OUTPUT_OFFSET:  output_offset_reg  <= pwdata[7:0];
                qprelu_pkg::REG_CHANNEL_TOTAL:
                    channel_total_reg <= pwdata[qprelu_pkg::CHAN_FIELD_W-1:0];
                qprelu_pkg::REG_PLANE_ELEMENTS:
                    plane_elements_reg <= pwdata[qprelu_pkg::PLANE_FIELD_W-1:0];
                qprelu_pkg::REG_POS_GAIN:       pos_gain_reg       <= pwdata;
                qprelu_pkg::REG_NEG_GAIN:       neg_gain_reg       <= pwdata;
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            qprelu_pkg::REG_DATA_KIND:      prdata = qprelu_pkg::PDATA_W'(data_kind_reg);
            qprelu_pkg::REG_INPUT_OFFSET:   prdata = qprelu_pkg::PDATA_W'(input_offset_reg);
            qprelu_pkg::REG_SLOPE_OFFSET:   prdata = qprelu_pkg::PDATA_W'(slope_offset_reg);
            qprelu_pkg::REG_OUTPUT_OFFSET:  prdata = qprelu_pkg::PDATA_W'(output_offset_reg);
            qprelu_pkg::REG_CHANNEL_TOTAL:  prdata = qprelu_pkg::PDATA_W'(channel_total_reg);
            qprelu_pkg::REG_PLANE_ELEMENTS: prdata = qprelu_pkg::PDATA_W'(plane_elements_reg);
            qprelu_pkg::REG_POS_GAIN:       prdata = pos_gain_reg;
            qprelu_pkg::REG_NEG_GAIN:       prdata = neg_gain_reg;
            default:                        prdata = '0;
        endcase
    end

    assign size.channel_total   = channel_total_reg;
    assign size.plane_elements  = plane_elements_reg;

    assign arith_cfg.data_kind     = data_kind_reg;
    assign arith_cfg.input_offset  = input_offset_reg;
    assign arith_cfg.slope_offset  = slope_offset_reg;
    assign arith_cfg.output_offset = output_offset_reg;
    assign arith_cfg.pos_gain      = pos_gain_reg;
    assign arith_cfg.neg_gain      = neg_gain_reg;

    qprelu_front #(
        .CHANNEL_MAX (CHANNEL_MAX),
        .PLANE_MAX   (PLANE_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_value (s_tdata[7:0]),
        .in_index (s_tdata[15:8]),
        .size     (size),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    qprelu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    qprelu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (arith_cfg),
        .q_empty     (q_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (res_result),
        .out_clipped (m_tuser),
        .out_channel (res_channel)
    );

    assign m_tdata = {res_channel, res_result};

endmodule
